FILE: rtl/multi_level_threshold_monitor_unit_macros.svh
// Assertion macros used by the threshold monitor top level.
`ifndef MULTI_LEVEL_THRESHOLD_MONITOR_UNIT_MACROS_SVH
`define MULTI_LEVEL_THRESHOLD_MONITOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define MLTM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mltm assertion failed");
// Checked property that also holds during reset.
`define MLTM_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mltm reset assertion failed");
`else
`define MLTM_ASSERT(lbl, prop)
`define MLTM_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/mltm_pkg.sv
// Types, constants and the pair update function of the threshold monitor.
`timescale 1ns / 1ps

package mltm_pkg;

    localparam int CH_BITS        = 2;
    localparam int CHANNELS       = 1 << CH_BITS;
    localparam int SLOT_BITS      = 4;
    localparam int SLOTS          = 1 << SLOT_BITS;
    localparam int VALUE_BITS     = 16;
    localparam int FLAG_BITS      = 16;
    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_MASK_REGS  = 4;
    localparam int NIBBLE_BITS    = 4;
    localparam int REPORT_BIT     = 2;
    localparam int PAIRS = (SLOTS / 2 < FLAG_BITS / 2) ? SLOTS / 2 : FLAG_BITS / 2;

    typedef enum logic [1:0] {
        KIND_READING = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_REMOVE  = 2'd2
    } kind_e;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MASK_CH0    = 3'd0,
        CFG_MASK_CH1    = 3'd1,
        CFG_MASK_CH2    = 3'd2,
        CFG_MASK_CH3    = 3'd3,
        CFG_REPORT_MODE = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [CH_BITS-1:0]           channel;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [VALUE_BITS-1:0] value;
    } sample_t;

    typedef struct packed {
        logic [CH_BITS-1:0]           out_channel;
        logic                         report_reading;
        logic [FLAG_BITS-1:0]         triggered_flags;
        logic                         flags_changed;
        logic signed [VALUE_BITS-1:0] reading_echo;
    } result_t;

    // Request from the control logic to the threshold table.
    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic                  rm;
        logic [CH_BITS-1:0]    channel;
        logic [SLOT_BITS-1:0]  slot;
        logic [VALUE_BITS-1:0] value;
    } tbl_req_t;

    typedef logic [SLOTS-1:0][VALUE_BITS-1:0] row_t;

    // Hysteresis update of one high/low pair. Result bit 0 is the high flag,
    // bit 1 the low flag.
    function automatic logic [1:0] pair_update(
        input logic       ha,
        input logic       la,
        input logic       hp,
        input logic       lp,
        input logic       hgt,
        input logic       lgt,
        input logic [1:0] old
    );
        logic hr;
        logic lr;
        hr = old[0];
        lr = old[1];
        if (ha && hp)
        begin
            if (hgt)
            begin
                lr = 1'b0;
                hr = 1'b1;
            end
            else if (!la)
            begin
                hr = 1'b0;
            end
        end
        if (la && lp)
        begin
            if (!lgt)
            begin
                hr = 1'b0;
                lr = 1'b1;
            end
            else if (!ha)
            begin
                lr = 1'b0;
            end
        end
        return {lr, hr};
    endfunction

endpackage

FILE: rtl/mltm_table.sv
// Threshold table: one memory row per channel plus present bits per slot.
`timescale 1ns / 1ps

module mltm_table
    import mltm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_req_t         req,
    output row_t             rd_row,
    output logic [SLOTS-1:0] rd_present
);

    // Each row holds all slots of one channel; a write updates one slot lane.
    row_t                             thr_mem_reg [CHANNELS];
    row_t                             rd_row_reg;
    logic [SLOTS-1:0]                 rd_present_reg;
    logic [CHANNELS-1:0][SLOTS-1:0]   present_reg;
    logic [CHANNELS-1:0][SLOTS-1:0]   present_next;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            thr_mem_reg[req.channel][req.slot] <= req.value;
        end
        if (req.rd)
        begin
            rd_row_reg     <= thr_mem_reg[req.channel];
            rd_present_reg <= present_reg[req.channel];
        end
    end

    always_comb
    begin
        present_next = present_reg;
        if (req.wr)
        begin
            present_next[req.channel][req.slot] = 1'b1;
        end
        else if (req.rm)
        begin
            present_next[req.channel][req.slot] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else
        begin
            present_reg <= present_next;
        end
    end

    assign rd_row     = rd_row_reg;
    assign rd_present = rd_present_reg;

endmodule

FILE: rtl/multi_level_threshold_monitor_unit.sv
// Top level of the multi-level threshold monitor with hysteresis.
// Usage: the sample channel (sample_valid, sample_ready, sample) carries one word per item:
// a reading, a threshold write or a threshold removal for one of four channels. Only
// readings produce a word on the result channel (result_valid, result_ready, result).
// A new sample word is taken every cycle while sample_ready is high. The channel's
// threshold row is read at the edge that accepts a reading; the evaluation stage then
// computes all pair compares in parallel and loads the output register, from which the
// result word leaves when result_ready is high.
// The row read of each reading is the only memory access that a reading waits for;
// writes and removals finish in the cycle they are accepted.
// When the receiver stalls, the output register holds its word, the evaluation stage
// keeps one more reading, and sample_ready drops only once both are occupied.
// At reset the configuration registers, present bits and stored triggered flags clear
// at once; there is no clearing pass. Threshold values are undefined until written,
// which is harmless because a slot is compared only while its present bit is set.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data while idle.
`timescale 1ns / 1ps
`include "multi_level_threshold_monitor_unit_macros.svh"

module multi_level_threshold_monitor_unit
    import mltm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  sample_t                   sample,
    output logic                      result_valid,
    input  logic                      result_ready,
    output result_t                   result,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    // Configuration registers.
    logic [NUM_MASK_REGS-1:0][CFG_BITS-1:0] mask_reg;
    logic [NUM_MASK_REGS-1:0][CFG_BITS-1:0] mask_next;
    logic [CFG_BITS-1:0]                    report_mode_reg;
    logic [CFG_BITS-1:0]                    report_mode_next;

    // Stored triggered flags, one word per channel.
    logic [CHANNELS-1:0][FLAG_BITS-1:0]     trig_reg;
    logic [CHANNELS-1:0][FLAG_BITS-1:0]     trig_next;

    // Evaluation stage: the reading waits here while its table row is read.
    logic                                   s1_valid_reg;
    logic                                   s1_valid_next;
    logic [CH_BITS-1:0]                     s1_channel_reg;
    logic signed [VALUE_BITS-1:0]           s1_value_reg;
    logic                                   s1_report_reg;

    // Output register.
    logic                                   result_valid_reg;
    logic                                   result_valid_next;
    result_t                                result_reg;

    logic                                   sample_accept;
    logic                                   out_advance;
    logic                                   s1_fire;
    tbl_req_t                               tbl_req;
    row_t                                   rd_row;
    logic [SLOTS-1:0]                       rd_present;
    logic [FLAG_BITS-1:0]                   old_flags;
    logic [FLAG_BITS-1:0]                   new_flags;
    logic [CFG_BITS-1:0]                    act_mask;

    assign out_advance   = !result_valid_reg || result_ready;
    assign s1_fire       = s1_valid_reg && out_advance;
    assign sample_ready  = !s1_valid_reg || out_advance;
    assign sample_accept = sample_valid && sample_ready;

    // Writes and removals go straight into the table at acceptance. A reading
    // starts its row read at the same edge, so it always sees every earlier
    // write, and no later write can reach the row it holds: no forwarding needed.
    always_comb
    begin
        tbl_req.rd      = sample_accept && (sample.kind == KIND_READING);
        tbl_req.wr      = sample_accept && (sample.kind == KIND_WRITE);
        tbl_req.rm      = sample_accept && (sample.kind == KIND_REMOVE);
        tbl_req.channel = sample.channel;
        tbl_req.slot    = sample.slot;
        tbl_req.value   = sample.value;
    end

    mltm_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (tbl_req),
        .rd_row     (rd_row),
        .rd_present (rd_present)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tbl_req.rd)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // The report-only bit is sampled at acceptance; configuration must only change
    // while idle, a rule the user keeps, so this equals the value at evaluation time.
    always_ff @(posedge clk)
    begin
        if (tbl_req.rd)
        begin
            s1_channel_reg <= sample.channel;
            s1_value_reg   <= sample.value;
            s1_report_reg  <= report_mode_reg[{sample.channel, 2'(REPORT_BIT)}];
        end
    end

    // Pair evaluation: all pairs are independent and are computed side by side.
    always_comb
    begin
        old_flags = trig_reg[s1_channel_reg];
        act_mask  = mask_reg[s1_channel_reg];
        new_flags = old_flags;
        for (int p = 0; p < PAIRS; p++)
        begin
            new_flags[2*p +: 2] = pair_update(
                act_mask[2*p],
                act_mask[2*p+1],
                rd_present[2*p],
                rd_present[2*p+1],
                s1_value_reg > $signed(rd_row[2*p]),
                s1_value_reg > $signed(rd_row[2*p+1]),
                old_flags[2*p +: 2]
            );
        end
    end

    // The stored flags are updated when a reading that is not report-only leaves the
    // evaluation stage, so a following reading of the same channel sees the new word.
    always_comb
    begin
        trig_next = trig_reg;
        if (s1_fire && !s1_report_reg)
        begin
            trig_next[s1_channel_reg] = new_flags;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (s1_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            result_reg.out_channel    <= s1_channel_reg;
            result_reg.report_reading <= s1_report_reg;
            result_reg.reading_echo   <= s1_value_reg;
            if (s1_report_reg)
            begin
                result_reg.triggered_flags <= old_flags;
                result_reg.flags_changed   <= 1'b0;
            end
            else
            begin
                result_reg.triggered_flags <= new_flags;
                result_reg.flags_changed   <= (new_flags != old_flags);
            end
        end
    end

    // Configuration writes; indices beyond the register list are dropped.
    always_comb
    begin
        mask_next        = mask_reg;
        report_mode_next = report_mode_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MASK_CH0:    mask_next[0]     = cfg_data;
                CFG_MASK_CH1:    mask_next[1]     = cfg_data;
                CFG_MASK_CH2:    mask_next[2]     = cfg_data;
                CFG_MASK_CH3:    mask_next[3]     = cfg_data;
                CFG_REPORT_MODE: report_mode_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg         <= '0;
            report_mode_reg  <= '0;
            trig_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg         <= mask_next;
            report_mode_reg  <= report_mode_next;
            trig_reg         <= trig_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Backpressure only when both the evaluation stage and the output are full.
    `MLTM_ASSERT(a_ready_only_when_full, !sample_ready |-> s1_valid_reg && result_valid_reg && !result_ready)
    // An accepted reading always occupies the evaluation stage next cycle.
    `MLTM_ASSERT(a_reading_enters_s1, tbl_req.rd |=> s1_valid_reg)
    // Stored flags change only when a checked reading completes.
    `MLTM_ASSERT(a_trig_stable, !(s1_fire && !s1_report_reg) |=> $stable(trig_reg))
    // A report-only result never claims a flag change.
    `MLTM_ASSERT(a_report_no_change, result_valid && result.report_reading |-> !result.flags_changed)
    // Once reset has been seen at an edge, no result is offered at the next one.
    `MLTM_ASSERT_RST(a_reset_quiet, !rst_n |=> !result_valid && !s1_valid_reg)

endmodule
